// ===== hdl/euler_camera_orientation_update_defines.svh =====
// ----------------------------------------------------------------------------
// euler camera orientation update - assertion macros
// shared concurrent check helpers for the camera block
// ----------------------------------------------------------------------------
`ifndef EULER_CAMERA_ORIENTATION_UPDATE_DEFINES_SVH
`define EULER_CAMERA_ORIENTATION_UPDATE_DEFINES_SVH

// same-cycle implication
`define ECOU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ECOU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ecou_pkg.sv =====
// ----------------------------------------------------------------------------
// ecou_pkg
// constants, types and rounding helpers of the camera orientation block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ecou_pkg;

   localparam int VECTOR_FRAC_BITS = 14;
   localparam int VEC_W   = 16;
   localparam int POS_W   = 32;
   localparam int ANG_W   = 28;
   localparam int YAW_W   = 26;
   localparam int PITCH_W = 24;
   localparam int RED_W   = 23;
   localparam int TRIG_W  = 32;

   localparam int LOOK_GAIN = 3277;
   localparam int DEG90     = 90 * 65536;
   localparam int DEG360    = 360 * 65536;

   localparam logic [TRIG_W-1:0] ONE30 = 32'h4000_0000;
   localparam logic [31:0] PI_Q30 = 32'd3373259426;

   localparam int MUL_W  = 33;
   localparam int PROD_W = 2 * MUL_W;

   localparam int DIV_W    = 40;
   localparam int DVS_W    = 8;
   localparam int DIV_STEP = 4;
   localparam int DIV_ITER = DIV_W / DIV_STEP;

   localparam int SH1 = 30 - VECTOR_FRAC_BITS;
   localparam int SH2 = 60 - VECTOR_FRAC_BITS;
   localparam int MOVE_SH   = VECTOR_FRAC_BITS - 8;
   localparam int MOVE_DIV  = 100;
   localparam int MOVE_HALF = (MOVE_DIV << MOVE_SH) / 2;

   localparam logic [VEC_W-1:0] VEC_ONE = VEC_W'(1 << VECTOR_FRAC_BITS);

   localparam logic MODE_LOOK = 1'b0;
   localparam logic MODE_KEY  = 1'b1;

   localparam logic [1:0] CSR_START_X = 2'd0;
   localparam logic [1:0] CSR_START_Y = 2'd1;
   localparam logic [1:0] CSR_START_Z = 2'd2;

   // polynomial sequence steps
   localparam logic [2:0] PSTEP_ANGLE  = 3'd0;
   localparam logic [2:0] PSTEP_SQUARE = 3'd1;
   localparam logic [2:0] PSTEP_FIRST  = 3'd2;
   localparam logic [2:0] PSTEP_LAST   = 3'd6;
   localparam logic [2:0] PSTEP_FINAL  = 3'd7;

   typedef enum logic [2:0] {
      KEY_NONE  = 3'd0,
      KEY_FWD   = 3'd1,
      KEY_BACK  = 3'd2,
      KEY_LEFT  = 3'd3,
      KEY_RIGHT = 3'd4,
      KEY_UP    = 3'd5,
      KEY_DOWN  = 3'd6
   } key_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   function automatic logic [DVS_W-1:0] poly_divisor(input logic [2:0] step);
      logic [DVS_W-1:0] d;
      case (step)
         PSTEP_ANGLE: d = 8'd180;
         3'd2:        d = 8'd110;
         3'd3:        d = 8'd72;
         3'd4:        d = 8'd42;
         3'd5:        d = 8'd20;
         3'd6:        d = 8'd6;
         default:     d = 8'd1;
      endcase
      return d;
   endfunction

   // round half away from zero, q30 to vector format
   function automatic logic [VEC_W-1:0] rnd_q30(input logic signed [31:0] v);
      logic [32:0]      mag;
      logic [32:0]      sum;
      logic [VEC_W-1:0] r;
      mag = v[31] ? (33'd0 - 33'(v)) : 33'(v);
      sum = mag + (33'd1 << (SH1 - 1));
      r   = VEC_W'(sum >> SH1);
      return v[31] ? (VEC_W'(0) - r) : r;
   endfunction

   // round half away from zero, q60 to vector format
   function automatic logic [VEC_W-1:0] rnd_q60(input logic signed [PROD_W-1:0] v);
      logic [PROD_W:0]  mag;
      logic [PROD_W:0]  sum;
      logic [VEC_W-1:0] r;
      mag = v[PROD_W-1] ? ((PROD_W+1)'(0) - (PROD_W+1)'(v)) : (PROD_W+1)'(v);
      sum = mag + ((PROD_W+1)'(1) << (SH2 - 1));
      r   = VEC_W'(sum >> SH2);
      return v[PROD_W-1] ? (VEC_W'(0) - r) : r;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ecou_mul.sv =====
// ----------------------------------------------------------------------------
// ecou_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ecou_mul (
   input  wire logic                                  clock,
   input  wire logic signed [ecou_pkg::MUL_W-1:0]     mul_a,
   input  wire logic signed [ecou_pkg::MUL_W-1:0]     mul_b,
   output logic signed [ecou_pkg::PROD_W-1:0]         prod
);

   logic signed [ecou_pkg::PROD_W-1:0] prod_ff;
   logic signed [ecou_pkg::PROD_W-1:0] prod_in;

   assign prod_in = ecou_pkg::PROD_W'(mul_a) * ecou_pkg::PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== hdl/ecou_div.sv =====
// ----------------------------------------------------------------------------
// ecou_div
// shared unsigned divider, narrow divisor, four quotient bits per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "euler_camera_orientation_update_defines.svh"

module ecou_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ecou_pkg::div_req_type div_req,
   output ecou_pkg::div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(ecou_pkg::DIV_ITER);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [ecou_pkg::DIV_W-1:0]      num_ff, num_in;
   logic [ecou_pkg::DVS_W-1:0]      rem_ff, rem_in;
   logic [ecou_pkg::DVS_W-1:0]      dvs_ff, dvs_in;
   logic [ecou_pkg::DIV_W-1:0]      num_v;
   logic [ecou_pkg::DVS_W-1:0]      rem_v;
   logic [ecou_pkg::DVS_W:0]        trial;

   // radix-16 restoring step
   always_comb begin
      rem_v = rem_ff;
      num_v = num_ff;
      trial = '0;
      for (int i = 0; i < ecou_pkg::DIV_STEP; i++) begin
         trial = {rem_v, num_v[ecou_pkg::DIV_W-1]};
         num_v = {num_v[ecou_pkg::DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            trial    = trial - {1'b0, dvs_ff};
            num_v[0] = 1'b1;
         end
         rem_v = trial[ecou_pkg::DVS_W-1:0];
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         num_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         num_in = num_v;
         rem_in = rem_v;
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(ecou_pkg::DIV_ITER - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

   `ECOU_ASSERT_NOW(a_div_start_idle, clock, reset, div_req.start, !busy_ff, "divider restarted while busy")

endmodule

`default_nettype wire

// ===== hdl/euler_camera_orientation_update.sv =====
// ----------------------------------------------------------------------------
// euler_camera_orientation_update
// yaw/pitch free-fly camera: angle update, basis rebuild and key moves
// ----------------------------------------------------------------------------
//  channel | ports                  | word
//  --------+------------------------+--------------------------------------
//  req     | req_tvalid/tready      | tuser mode, tdata look/key fields
//  rsp     | rsp_tvalid/tready      | tdata position and basis vectors
//  csr     | csr_we/addr/wdata      | start position, loads position
//
//  a look word runs four sine polynomials, each with six quotients from the
//  shared divider, plus one shared multiplier
//  a key word makes three divider passes, one per axis
//  one word is in flight at a time; req_tready is low until rsp is taken
//  synchronous reset loads the start position and the level basis
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "euler_camera_orientation_update_defines.svh"

module euler_camera_orientation_update (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // look_dx, look_dy, key_code, pressed, frame_time, zero pad
   input  wire logic [55:0]  req_tdata,
   // mode
   input  wire logic         req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // pos_x, pos_y, pos_z, front_x/y/z, right_x/y/z, up_x/y/z
   output logic [239:0]      rsp_tdata,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_addr,
   input  wire logic [31:0]  csr_wdata
);

   localparam int VW = ecou_pkg::VEC_W;
   localparam int AW = ecou_pkg::ANG_W;
   localparam int PW = ecou_pkg::POS_W;
   localparam int TW = ecou_pkg::TRIG_W;

   localparam logic signed [AW-1:0] A_DEG90  = AW'(ecou_pkg::DEG90);
   localparam logic signed [AW-1:0] A_DEG360 = AW'(ecou_pkg::DEG360);
   localparam logic signed [AW-1:0] A_GAIN   = AW'(ecou_pkg::LOOK_GAIN);
   localparam logic signed [ecou_pkg::PITCH_W-1:0] P_DEG90 =
      ecou_pkg::PITCH_W'(ecou_pkg::DEG90);
   localparam logic signed [ecou_pkg::YAW_W-1:0] Y_DEG360 =
      ecou_pkg::YAW_W'(ecou_pkg::DEG360);
   localparam logic signed [PW-1:0] POS_RESET_X = -32'sd327680;
   localparam logic signed [PW+1:0] SAT_MAX = (PW+2)'(2147483647);
   localparam logic signed [PW+1:0] SAT_MIN = -SAT_MAX - (PW+2)'(1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOOK, ST_WRAP, ST_RED, ST_PMUL, ST_PPOST, ST_PDIV,
      ST_VMUL, ST_VPOST, ST_VFIN, ST_MMUL, ST_MPOST, ST_MDIV, ST_OUT
   } state_type;

   state_type                              state_ff, state_in;
   logic signed [15:0]                     dx_ff, dx_in, dy_ff, dy_in;
   ecou_pkg::key_type                      key_ff, key_in;
   logic [15:0]                            ft_ff, ft_in;
   logic signed [ecou_pkg::YAW_W-1:0]      yaw_ff, yaw_in;
   logic signed [ecou_pkg::PITCH_W-1:0]    pitch_ff, pitch_in;
   logic signed [AW-1:0]                   wrap_ff, wrap_in;
   logic                                   ang_sel_ff, ang_sel_in;
   logic                                   half_sel_ff, half_sel_in;
   logic [1:0]                             quad_ff, quad_in;
   logic [ecou_pkg::RED_W-1:0]             red_ff, red_in;
   logic [2:0]                             step_ff, step_in;
   logic [TW-1:0]                          t_ff, t_in, t2_ff, t2_in, p_ff, p_in;
   logic signed [TW-1:0]                   sv_ff, sv_in;
   logic signed [TW-1:0]                   sy_ff, sy_in, cy_ff, cy_in;
   logic signed [TW-1:0]                   sp_ff, sp_in, cp_ff, cp_in;
   logic [1:0]                             vsel_ff, vsel_in;
   logic [1:0]                             comp_ff, comp_in;
   logic signed [PW-1:0]                   pos_ff [3];
   logic signed [PW-1:0]                   pos_in [3];
   logic [VW-1:0]                          front_ff [3];
   logic [VW-1:0]                          front_in [3];
   logic [VW-1:0]                          right_ff [3];
   logic [VW-1:0]                          right_in [3];
   logic [VW-1:0]                          up_ff [3];
   logic [VW-1:0]                          up_in [3];

   // shared units
   logic signed [ecou_pkg::MUL_W-1:0]      mul_a, mul_b;
   logic signed [ecou_pkg::PROD_W-1:0]     prod;
   ecou_pkg::div_req_type                  div_req;
   ecou_pkg::div_rsp_type                  div_rsp;

   // scratch
   logic signed [AW-1:0]                   yaw_sum, pitch_sum, ang, ang_u;
   logic [ecou_pkg::RED_W-1:0]             poly_arg;
   logic signed [TW-1:0]                   res, s_val, c_val;
   logic [VW-1:0]                          vprod;
   logic [VW-1:0]                          dir;
   logic [VW-1:0]                          dir_mag;
   logic                                   move_neg;
   logic signed [PW:0]                     move_step;
   logic signed [PW+1:0]                   move_sum;

   ecou_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   ecou_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // look update sums
   assign yaw_sum   = AW'(yaw_ff) + AW'(dx_ff) * A_GAIN;
   assign pitch_sum = AW'(pitch_ff) + AW'(dy_ff) * A_GAIN;

   // angle folded into [0, 360)
   assign ang      = ang_sel_ff ? AW'(pitch_ff) : AW'(yaw_ff);
   assign ang_u    = ang[AW-1] ? (ang + A_DEG360) : ang;
   assign poly_arg = half_sel_ff ? (ecou_pkg::RED_W'(ecou_pkg::DEG90) - red_ff) : red_ff;

   // polynomial result and quadrant mapping
   assign res = TW'(prod[61:30]);
   always_comb begin
      case (quad_ff)
         2'd0:    begin s_val = sv_ff;  c_val = res;    end
         2'd1:    begin s_val = res;    c_val = -sv_ff; end
         2'd2:    begin s_val = -sv_ff; c_val = -res;   end
         default: begin s_val = -res;   c_val = sv_ff;  end
      endcase
   end

   assign vprod = ecou_pkg::rnd_q60(prod);

   // move direction for the current axis
   always_comb begin
      case (key_ff)
         ecou_pkg::KEY_FWD, ecou_pkg::KEY_BACK:   dir = front_ff[comp_ff];
         ecou_pkg::KEY_LEFT, ecou_pkg::KEY_RIGHT: dir = right_ff[comp_ff];
         ecou_pkg::KEY_UP, ecou_pkg::KEY_DOWN:
            dir = (comp_ff == 2'd1) ? ecou_pkg::VEC_ONE : '0;
         default: dir = '0;
      endcase
   end
   assign move_neg = (key_ff == ecou_pkg::KEY_BACK) || (key_ff == ecou_pkg::KEY_LEFT) ||
                     (key_ff == ecou_pkg::KEY_DOWN);
   assign dir_mag  = dir[VW-1] ? (VW'(0) - dir) : dir;
   assign move_step = (dir[VW-1] != move_neg) ? -(PW+1)'(div_rsp.quotient[PW-1:0])
                                               : (PW+1)'(div_rsp.quotient[PW-1:0]);
   assign move_sum  = (PW+2)'(pos_ff[comp_ff]) + (PW+2)'(move_step);

   // sequencer
   always_comb begin
      state_in    = state_ff;
      dx_in       = dx_ff;
      dy_in       = dy_ff;
      key_in      = key_ff;
      ft_in       = ft_ff;
      yaw_in      = yaw_ff;
      pitch_in    = pitch_ff;
      wrap_in     = wrap_ff;
      ang_sel_in  = ang_sel_ff;
      half_sel_in = half_sel_ff;
      quad_in     = quad_ff;
      red_in      = red_ff;
      step_in     = step_ff;
      t_in        = t_ff;
      t2_in       = t2_ff;
      p_in        = p_ff;
      sv_in       = sv_ff;
      sy_in       = sy_ff;
      cy_in       = cy_ff;
      sp_in       = sp_ff;
      cp_in       = cp_ff;
      vsel_in     = vsel_ff;
      comp_in     = comp_ff;
      pos_in      = pos_ff;
      front_in    = front_ff;
      right_in    = right_ff;
      up_in       = up_ff;
      mul_a       = '0;
      mul_b       = '0;
      div_req     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               dx_in  = req_tdata[15:0];
               dy_in  = req_tdata[31:16];
               key_in = ecou_pkg::key_type'(req_tdata[34:32]);
               ft_in  = req_tdata[51:36];
               comp_in = 2'd0;
               if (req_tuser == ecou_pkg::MODE_LOOK) begin
                  state_in = ST_LOOK;
               end else if (req_tdata[35] && (req_tdata[34:32] >= ecou_pkg::KEY_FWD) &&
                            (req_tdata[34:32] <= ecou_pkg::KEY_DOWN)) begin
                  state_in = ST_MMUL;
               end else begin
                  // release or unknown key
                  state_in = ST_OUT;
               end
            end
         end
         ST_LOOK: begin
            wrap_in = yaw_sum;
            if (pitch_sum > A_DEG90) begin
               pitch_in = P_DEG90;
            end else if (pitch_sum < -A_DEG90) begin
               pitch_in = -P_DEG90;
            end else begin
               pitch_in = ecou_pkg::PITCH_W'(pitch_sum);
            end
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            // truncated modulo, sign kept
            if (wrap_ff >= A_DEG360) begin
               wrap_in = wrap_ff - A_DEG360;
            end else if (wrap_ff <= -A_DEG360) begin
               wrap_in = wrap_ff + A_DEG360;
            end else begin
               yaw_in     = ecou_pkg::YAW_W'(wrap_ff);
               ang_sel_in = 1'b0;
               state_in   = ST_RED;
            end
         end
         ST_RED: begin
            if (ang_u >= 3 * A_DEG90) begin
               quad_in = 2'd3;
               red_in  = ecou_pkg::RED_W'(ang_u - 3 * A_DEG90);
            end else if (ang_u >= 2 * A_DEG90) begin
               quad_in = 2'd2;
               red_in  = ecou_pkg::RED_W'(ang_u - 2 * A_DEG90);
            end else if (ang_u >= A_DEG90) begin
               quad_in = 2'd1;
               red_in  = ecou_pkg::RED_W'(ang_u - A_DEG90);
            end else begin
               quad_in = 2'd0;
               red_in  = ecou_pkg::RED_W'(ang_u);
            end
            half_sel_in = 1'b0;
            step_in     = ecou_pkg::PSTEP_ANGLE;
            state_in    = ST_PMUL;
         end
         ST_PMUL: begin
            case (step_ff)
               ecou_pkg::PSTEP_ANGLE: begin
                  mul_a = ecou_pkg::MUL_W'(poly_arg);
                  mul_b = ecou_pkg::MUL_W'(ecou_pkg::PI_Q30);
               end
               ecou_pkg::PSTEP_SQUARE: begin
                  mul_a = ecou_pkg::MUL_W'(t_ff);
                  mul_b = ecou_pkg::MUL_W'(t_ff);
               end
               ecou_pkg::PSTEP_FINAL: begin
                  mul_a = ecou_pkg::MUL_W'(t_ff);
                  mul_b = ecou_pkg::MUL_W'(p_ff);
               end
               default: begin
                  mul_a = ecou_pkg::MUL_W'(t2_ff);
                  mul_b = ecou_pkg::MUL_W'(p_ff);
               end
            endcase
            state_in = ST_PPOST;
         end
         ST_PPOST: begin
            case (step_ff)
               ecou_pkg::PSTEP_ANGLE: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = ecou_pkg::DIV_W'(prod[55:16]);
                  div_req.divisor  = ecou_pkg::poly_divisor(step_ff);
                  state_in         = ST_PDIV;
               end
               ecou_pkg::PSTEP_SQUARE: begin
                  t2_in            = TW'(prod[61:30]);
                  div_req.start    = 1'b1;
                  div_req.dividend = ecou_pkg::DIV_W'(prod[65:30]);
                  div_req.divisor  = ecou_pkg::poly_divisor(ecou_pkg::PSTEP_FIRST);
                  step_in          = ecou_pkg::PSTEP_FIRST;
                  state_in         = ST_PDIV;
               end
               ecou_pkg::PSTEP_FINAL: begin
                  if (!half_sel_ff) begin
                     sv_in       = res;
                     half_sel_in = 1'b1;
                     step_in     = ecou_pkg::PSTEP_ANGLE;
                     state_in    = ST_PMUL;
                  end else if (!ang_sel_ff) begin
                     sy_in      = s_val;
                     cy_in      = c_val;
                     ang_sel_in = 1'b1;
                     state_in   = ST_RED;
                  end else begin
                     sp_in    = s_val;
                     cp_in    = c_val;
                     vsel_in  = 2'd0;
                     state_in = ST_VMUL;
                  end
               end
               default: begin
                  div_req.start    = 1'b1;
                  div_req.dividend = ecou_pkg::DIV_W'(prod[65:30]);
                  div_req.divisor  = ecou_pkg::poly_divisor(step_ff);
                  state_in         = ST_PDIV;
               end
            endcase
         end
         ST_PDIV: begin
            if (div_rsp.done) begin
               if (step_ff == ecou_pkg::PSTEP_ANGLE) begin
                  t_in    = TW'(div_rsp.quotient[TW-1:0]);
                  step_in = ecou_pkg::PSTEP_SQUARE;
               end else begin
                  p_in    = ecou_pkg::ONE30 - div_rsp.quotient[TW-1:0];
                  step_in = step_ff + 3'd1;
               end
               state_in = ST_PMUL;
            end
         end
         ST_VMUL: begin
            mul_a    = vsel_ff[0] ? ecou_pkg::MUL_W'(sy_ff) : ecou_pkg::MUL_W'(cy_ff);
            mul_b    = vsel_ff[1] ? ecou_pkg::MUL_W'(sp_ff) : ecou_pkg::MUL_W'(cp_ff);
            state_in = ST_VPOST;
         end
         ST_VPOST: begin
            case (vsel_ff)
               2'd0:    front_in[0] = vprod;
               2'd1:    front_in[2] = vprod;
               2'd2:    up_in[0]    = VW'(0) - vprod;
               default: up_in[2]    = VW'(0) - vprod;
            endcase
            vsel_in  = vsel_ff + 2'd1;
            state_in = (vsel_ff == 2'd3) ? ST_VFIN : ST_VMUL;
         end
         ST_VFIN: begin
            front_in[1] = ecou_pkg::rnd_q30(sp_ff);
            right_in[0] = VW'(0) - ecou_pkg::rnd_q30(sy_ff);
            right_in[1] = '0;
            right_in[2] = ecou_pkg::rnd_q30(cy_ff);
            up_in[1]    = ecou_pkg::rnd_q30(cp_ff);
            state_in    = ST_OUT;
         end
         ST_MMUL: begin
            mul_a    = ecou_pkg::MUL_W'(dir_mag);
            mul_b    = ecou_pkg::MUL_W'(ft_ff);
            state_in = ST_MPOST;
         end
         ST_MPOST: begin
            div_req.start    = 1'b1;
            div_req.dividend = ecou_pkg::DIV_W'(
               (prod + ecou_pkg::PROD_W'(ecou_pkg::MOVE_HALF)) >>> ecou_pkg::MOVE_SH);
            div_req.divisor  = ecou_pkg::DVS_W'(ecou_pkg::MOVE_DIV);
            state_in         = ST_MDIV;
         end
         ST_MDIV: begin
            if (div_rsp.done) begin
               // saturate to the 32 bit range
               if (move_sum > SAT_MAX) begin
                  pos_in[comp_ff] = PW'(SAT_MAX);
               end else if (move_sum < SAT_MIN) begin
                  pos_in[comp_ff] = PW'(SAT_MIN);
               end else begin
                  pos_in[comp_ff] = PW'(move_sum);
               end
               comp_in  = comp_ff + 2'd1;
               state_in = (comp_ff == 2'd2) ? ST_OUT : ST_MMUL;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // start writes also load the position
      if (csr_we) begin
         case (csr_addr)
            ecou_pkg::CSR_START_X: pos_in[0] = csr_wdata;
            ecou_pkg::CSR_START_Y: pos_in[1] = csr_wdata;
            ecou_pkg::CSR_START_Z: pos_in[2] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         yaw_ff      <= '0;
         pitch_ff    <= '0;
         pos_ff[0]   <= POS_RESET_X;
         pos_ff[1]   <= '0;
         pos_ff[2]   <= '0;
         front_ff[0] <= ecou_pkg::VEC_ONE;
         front_ff[1] <= '0;
         front_ff[2] <= '0;
         right_ff[0] <= '0;
         right_ff[1] <= '0;
         right_ff[2] <= ecou_pkg::VEC_ONE;
         up_ff[0]    <= '0;
         up_ff[1]    <= ecou_pkg::VEC_ONE;
         up_ff[2]    <= '0;
      end else begin
         state_ff <= state_in;
         yaw_ff   <= yaw_in;
         pitch_ff <= pitch_in;
         pos_ff   <= pos_in;
         front_ff <= front_in;
         right_ff <= right_in;
         up_ff    <= up_in;
      end
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      key_ff      <= key_in;
      ft_ff       <= ft_in;
      wrap_ff     <= wrap_in;
      ang_sel_ff  <= ang_sel_in;
      half_sel_ff <= half_sel_in;
      quad_ff     <= quad_in;
      red_ff      <= red_in;
      step_ff     <= step_in;
      t_ff        <= t_in;
      t2_ff       <= t2_in;
      p_ff        <= p_in;
      sv_ff       <= sv_in;
      sy_ff       <= sy_in;
      cy_ff       <= cy_in;
      sp_ff       <= sp_in;
      cp_ff       <= cp_in;
      vsel_ff     <= vsel_in;
      comp_ff     <= comp_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {up_ff[2], up_ff[1], up_ff[0],
                        right_ff[2], right_ff[1], right_ff[0],
                        front_ff[2], front_ff[1], front_ff[0],
                        pos_ff[2], pos_ff[1], pos_ff[0]};

   `ECOU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "ready right after accepting a word")
   `ECOU_ASSERT_NEXT(a_idle_after_rsp, clock, reset, rsp_tvalid && rsp_tready, req_tready, "not ready after result taken")
   `ECOU_ASSERT_NOW(a_pitch_clamped, clock, reset, 1'b1, (pitch_ff <= P_DEG90) && (pitch_ff >= -P_DEG90), "pitch beyond the poles")
   `ECOU_ASSERT_NOW(a_yaw_wrapped, clock, reset, req_tready, (yaw_ff < Y_DEG360) && (yaw_ff > -Y_DEG360), "yaw not wrapped")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb - camera orientation update bench
// streams look and key words into the camera block under random bursts,
// gaps and output stalls, predicts every result word, checks each field and
// reloads the start position between phases
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   // register index that the block must ignore
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam longint unsigned PI_Q30_L  = 64'd3373259426;
   localparam longint unsigned RAD_DIV_L = 64'd11796480;
   localparam longint unsigned ONE30_L   = 64'd1 << 30;

   typedef struct {
      logic        mode;
      logic [15:0] dx;
      logic [15:0] dy;
      logic [2:0]  key;
      logic        pressed;
      logic [15:0] ft;
   } cam_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [55:0]   req_tdata  = '0;
   logic          req_tuser  = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [239:0]  rsp_tdata;
   logic          csr_we    = 1'b0;
   logic [1:0]    csr_addr  = '0;
   logic [31:0]   csr_wdata = '0;

   euler_camera_orientation_update DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // camera predictor state
   // ------------------------------------------------------------------------
   longint cam_yaw, cam_pitch;
   longint cam_pos [3];
   longint cam_front [3];
   longint cam_right [3];
   longint cam_up [3];

   cam_word_type  pending_words [$];
   logic [239:0]  expected_state [$];

   int error_count = 0;
   int words_sent  = 0;
   int looks_sent  = 0;
   int keys_sent   = 0;
   int results_seen = 0;
   int csr_writes  = 0;

   // truncated taylor sine of r (q16 degrees in [0,90]), result in q30
   function automatic longint unsigned poly_sine(input longint unsigned r);
      longint unsigned t, t2, p;
      t  = (r * PI_Q30_L) / RAD_DIV_L;
      t2 = (t * t) >> 30;
      p  = ONE30_L - t2 / 110;
      p  = ONE30_L - ((t2 * p) >> 30) / 72;
      p  = ONE30_L - ((t2 * p) >> 30) / 42;
      p  = ONE30_L - ((t2 * p) >> 30) / 20;
      p  = ONE30_L - ((t2 * p) >> 30) / 6;
      return (t * p) >> 30;
   endfunction

   function automatic void trig_pair(input longint a, output longint s, output longint c);
      longint u, q, r, sv, cv;
      u  = ((a % ecou_pkg::DEG360) + ecou_pkg::DEG360) % ecou_pkg::DEG360;
      q  = u / ecou_pkg::DEG90;
      r  = u - q * ecou_pkg::DEG90;
      sv = longint'(poly_sine(longint'(r)));
      cv = longint'(poly_sine(longint'(ecou_pkg::DEG90 - r)));
      case (q)
         0: begin s = sv;  c = cv;  end
         1: begin s = cv;  c = -sv; end
         2: begin s = -sv; c = -cv; end
         default: begin s = -cv; c = sv; end
      endcase
   endfunction

   // round half away from zero, dropping sh bits
   function automatic longint round_away(input longint v, input int sh);
      longint mag, r;
      mag = (v < 0) ? -v : v;
      r   = (mag + (64'sd1 <<< (sh - 1))) >>> sh;
      return (v < 0) ? -r : r;
   endfunction

   function automatic void rebuild_basis();
      longint sy, cy, sp, cp;
      trig_pair(cam_yaw, sy, cy);
      trig_pair(cam_pitch, sp, cp);
      cam_front[0] = round_away(cy * cp, ecou_pkg::SH2);
      cam_front[1] = round_away(sp, ecou_pkg::SH1);
      cam_front[2] = round_away(sy * cp, ecou_pkg::SH2);
      cam_right[0] = round_away(-sy, ecou_pkg::SH1);
      cam_right[1] = 0;
      cam_right[2] = round_away(cy, ecou_pkg::SH1);
      cam_up[0]    = round_away(-(cy * sp), ecou_pkg::SH2);
      cam_up[1]    = round_away(cp, ecou_pkg::SH1);
      cam_up[2]    = round_away(-(sy * sp), ecou_pkg::SH2);
   endfunction

   // move along dir (negated if back), each axis saturating to 32 bits
   function automatic void step_position(input longint dir [3], input bit back,
                                         input longint ft);
      longint den, mag, step, p;
      den = 64'sd100 <<< (ecou_pkg::VECTOR_FRAC_BITS - 8);
      for (int k = 0; k < 3; k++) begin
         mag  = (dir[k] < 0) ? -dir[k] : dir[k];
         step = (mag * ft + den / 2) / den;
         if ((dir[k] < 0) != back) step = -step;
         p = cam_pos[k] + step;
         if (p > SAT_HI) p = SAT_HI;
         if (p < SAT_LO) p = SAT_LO;
         cam_pos[k] = p;
      end
   endfunction

   function automatic void camera_reset();
      cam_pos[0] = -327680;
      cam_pos[1] = 0;
      cam_pos[2] = 0;
      cam_yaw    = 0;
      cam_pitch  = 0;
      rebuild_basis();
   endfunction

   // apply one word to the predictor and return the expected result word
   function automatic logic [239:0] advance_camera(input cam_word_type w);
      longint world_up [3];
      logic [239:0] res;
      world_up[0] = 0;
      world_up[1] = 64'sd1 <<< ecou_pkg::VECTOR_FRAC_BITS;
      world_up[2] = 0;
      if (w.mode == ecou_pkg::MODE_LOOK) begin
         cam_yaw   += longint'($signed(w.dx)) * ecou_pkg::LOOK_GAIN;
         cam_pitch += longint'($signed(w.dy)) * ecou_pkg::LOOK_GAIN;
         if (cam_pitch > ecou_pkg::DEG90)  cam_pitch = ecou_pkg::DEG90;
         if (cam_pitch < -ecou_pkg::DEG90) cam_pitch = -ecou_pkg::DEG90;
         cam_yaw = cam_yaw % ecou_pkg::DEG360;
         rebuild_basis();
      end else if (w.pressed) begin
         case (ecou_pkg::key_type'(w.key))
            ecou_pkg::KEY_FWD:   step_position(cam_front, 1'b0, longint'(w.ft));
            ecou_pkg::KEY_BACK:  step_position(cam_front, 1'b1, longint'(w.ft));
            ecou_pkg::KEY_LEFT:  step_position(cam_right, 1'b1, longint'(w.ft));
            ecou_pkg::KEY_RIGHT: step_position(cam_right, 1'b0, longint'(w.ft));
            ecou_pkg::KEY_UP:    step_position(world_up, 1'b0, longint'(w.ft));
            ecou_pkg::KEY_DOWN:  step_position(world_up, 1'b1, longint'(w.ft));
            default: ;  // unknown key leaves the camera alone
         endcase
      end
      for (int k = 0; k < 3; k++) begin
         res[32*k +: 32]        = cam_pos[k][31:0];
         res[96 + 16*k +: 16]   = cam_front[k][15:0];
         res[144 + 16*k +: 16]  = cam_right[k][15:0];
         res[192 + 16*k +: 16]  = cam_up[k][15:0];
      end
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // driver: bursts of words with random gaps, prediction at acceptance
   // ------------------------------------------------------------------------
   cam_word_type cur_word;
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_state.push_back(advance_camera(cur_word));
            words_sent++;
            if (cur_word.mode == ecou_pkg::MODE_LOOK) looks_sent++;
            else keys_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               cur_word = pending_words.pop_front();
               req_tdata <= {4'b0, cur_word.ft, cur_word.pressed, cur_word.key,
                             cur_word.dy, cur_word.dx};
               req_tuser  <= cur_word.mode;
               req_tvalid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // end of burst: pick the next gap and burst length
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
                  burst_left = $urandom_range(0, 12);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // monitor: stall pattern, one long hold-off, field compare
   // ------------------------------------------------------------------------
   string field_name [12] = '{"pos_x", "pos_y", "pos_z", "front_x", "front_y",
                              "front_z", "right_x", "right_y", "right_z",
                              "up_x", "up_y", "up_z"};
   int stall_mode  = 0;
   int stall_timer = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;

   always @(posedge clock) begin
      logic [239:0] want;
      int off;
      longint ev, av;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_state.size() == 0) begin
            $error("result word with nothing expected");
            error_count++;
         end else begin
            want = expected_state.pop_front();
            for (int k = 0; k < 12; k++) begin
               off = (k < 3) ? 32 * k : 96 + 16 * (k - 3);
               ev  = (k < 3) ? longint'($signed(want[off +: 32]))
                             : longint'($signed(want[off +: 16]));
               av  = (k < 3) ? longint'($signed(rsp_tdata[off +: 32]))
                             : longint'($signed(rsp_tdata[off +: 16]));
               if (ev != av) begin
                  $error("%s mismatch: expected %0d, got %0d", field_name[k], ev, av);
                  error_count++;
               end
            end
         end
      end
      // long hold-off once, while the sender keeps offering words
      if (!hold_done && results_seen == 300) begin
         hold_done = 1'b1;
         hold_left = 3000;
      end
      if (stall_timer == 0) begin
         stall_mode  = $urandom_range(0, 2);
         stall_timer = $urandom_range(50, 400);
      end else begin
         stall_timer--;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (stall_mode == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, stall_mode + 1) != 0);
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   function automatic cam_word_type look_word(input int dx, input int dy);
      cam_word_type w;
      w.mode = ecou_pkg::MODE_LOOK;  w.dx = dx[15:0];  w.dy = dy[15:0];
      w.key = 3'($urandom);  w.pressed = 1'($urandom);  w.ft = 16'($urandom);
      return w;
   endfunction

   function automatic cam_word_type key_word(input ecou_pkg::key_type k, input bit pr,
                                             input int ft);
      cam_word_type w;
      w.mode = ecou_pkg::MODE_KEY;  w.dx = 16'($urandom);  w.dy = 16'($urandom);
      w.key = k;          w.pressed = pr;   w.ft = ft[15:0];
      return w;
   endfunction

   function automatic cam_word_type random_word();
      cam_word_type w;
      if ($urandom_range(0, 1) == 0) begin
         // mostly small mouse offsets so the angles wander through all quadrants
         if ($urandom_range(0, 9) < 7)
            w = look_word($urandom_range(0, 800) - 400, $urandom_range(0, 400) - 200);
         else
            w = look_word($urandom, $urandom);
      end else begin
         w = key_word(ecou_pkg::key_type'($urandom_range(0, 7)),
                      $urandom_range(0, 7) != 0,
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4000));
      end
      return w;
   endfunction

   // settle on falling edges so every handshake of the rising edge is seen
   task automatic wait_idle();
      @(negedge clock);
      while (pending_words.size() != 0 || expected_state.size() != 0 || req_tvalid)
         @(negedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_start(input logic [1:0] idx, input logic [31:0] v);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= v;
      if (idx != CSR_UNUSED) cam_pos[idx] = longint'($signed(v));
      csr_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      ecou_pkg::key_type kc;
      camera_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: key set from the level pose, release, unknown key
      for (int k = 0; k < 8; k++) begin
         kc = ecou_pkg::key_type'(k);
         pending_words.push_back(key_word(kc, 1'b1, 16'hFFFF));
         pending_words.push_back(key_word(kc, 1'b0, 16'hFFFF));
      end
      pending_words.push_back(key_word(ecou_pkg::KEY_FWD, 1'b1, 0));
      // directed: extreme offsets, both pitch poles, zero look
      pending_words.push_back(look_word(32767, 32767));
      pending_words.push_back(key_word(ecou_pkg::KEY_LEFT, 1'b1, 16'hFFFF));
      pending_words.push_back(look_word(-32768, -32768));
      pending_words.push_back(key_word(ecou_pkg::KEY_FWD, 1'b1, 16'hFFFF));
      pending_words.push_back(look_word(0, 0));
      pending_words.push_back(look_word(1800, 0));
      wait_idle();

      // position saturation at both ends of the range
      write_start(ecou_pkg::CSR_START_X, 32'h7FFF_FFFF);
      write_start(ecou_pkg::CSR_START_Y, 32'h8000_0000);
      write_start(ecou_pkg::CSR_START_Z, 32'h7FFF_FF00);
      write_start(CSR_UNUSED, 32'h1234_5678);
      pending_words.push_back(look_word(-1800, 0));
      pending_words.push_back(key_word(ecou_pkg::KEY_FWD, 1'b1, 16'hFFFF));
      pending_words.push_back(key_word(ecou_pkg::KEY_DOWN, 1'b1, 16'hFFFF));
      pending_words.push_back(key_word(ecou_pkg::KEY_LEFT, 1'b1, 16'hFFFF));
      pending_words.push_back(key_word(ecou_pkg::KEY_BACK, 1'b1, 16'hFFFF));
      wait_idle();

      // random phases, start position reloaded between them
      for (int ph = 0; ph < 5; ph++) begin
         if (ph == 1) begin
            write_start(ecou_pkg::CSR_START_X, 32'h8000_0000);
            write_start(ecou_pkg::CSR_START_Y, 32'h7FFF_FFFF);
            write_start(ecou_pkg::CSR_START_Z, 32'h0000_0000);
         end else if (ph > 1) begin
            write_start(ecou_pkg::CSR_START_X, $urandom);
            write_start(ecou_pkg::CSR_START_Y, $urandom);
            write_start(ecou_pkg::CSR_START_Z,
                        $urandom_range(0, 1) ? 32'h7FFF_0000 : $urandom);
         end
         for (int i = 0; i < 310; i++) pending_words.push_back(random_word());
         wait_idle();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d words (%0d look, %0d key), %0d results, %0d csr writes",
               words_sent, looks_sent, keys_sent, results_seen, csr_writes);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog
   initial begin
      #200_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
